// ----- rtl/ncua_pkg.sv -----
// Shared types, constants and helpers for the nearest capable unit assigner.
`timescale 1ns / 1ps

package ncua_pkg;

  // Table size and the index width that follows from it
  localparam int UNITS  = 16;
  localparam int UNIT_W = $clog2(UNITS);

  // Field widths fixed by the stream format
  localparam int FIELD_IDX_W = 4;
  localparam int CAPS_W      = 4;
  localparam int POS_W       = 16;

  // Exact squared distance: two squares of 17-bit differences, summed
  localparam int DIFF_W = POS_W + 1;
  localparam int SQ_W   = 2 * POS_W;
  localparam int DIST_W = SQ_W + 1;

  // Item kinds carried on the input tuser
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_ASSIGN = 1'b1;

  // One stored table entry
  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [CAPS_W-1:0]       caps;
    logic                    seen;
  } unit_entry_t;

  localparam int ENTRY_W = $bits(unit_entry_t);

  // True when every required capability bit is present
  function automatic logic capable(input logic [CAPS_W-1:0] need,
                                   input logic [CAPS_W-1:0] caps);
    return (need & ~caps) == '0;
  endfunction

  // Map a 4-bit index field onto the table index width
  function automatic logic [UNIT_W-1:0] to_unit(input logic [FIELD_IDX_W-1:0] f);
    return UNIT_W'(f);
  endfunction

  // Index field within the table
  function automatic logic in_range(input logic [FIELD_IDX_W-1:0] f);
    return 32'(f) < 32'(UNITS);
  endfunction

endpackage

// ----- rtl/ncua_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ncua_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/nearest_capable_unit_assigner.sv -----
// Top level of the nearest capable unit assigner: sequencer, distance unit and pool.
`timescale 1ns / 1ps
// A write item is taken in the idle state and gives no result. An assign item whose holder
//   is kept passes through HREAD, HEVAL and FINISH into the output register; one that
//   searches also goes through SCAN, where the single read port walks every entry one per
//   cycle through the squared-distance pipeline. A result not yet taken holds the next one.
// Throughput: one item at a time; input ready only while the sequencer idles. Reset: rst_ni
//   clears the sequencer, entry valid bits and free pool, so no unit is free until written.

module nearest_capable_unit_assigner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata, from bit 0 up: unit_index[3:0], pos_x[19:4], pos_y[35:20], caps[39:36],
  // visible[40], in_pool[41], target_x[57:42], target_y[73:58],
  // require_mask[77:74], holder_valid[78], holder_index[82:79], zero fill[87:83]
  input  logic [87:0] s_axis_tdata,
  // tuser: op[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata, from bit 0 up: assigned_valid[0], assigned_index[4:1], kept_holder[5],
  // success[6], zero fill[7]
  output logic [7:0]  m_axis_tdata
);
  import ncua_pkg::*;

  localparam int CNT_W = UNIT_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HREAD,
    ST_HEVAL,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // Unpack the input item
  logic                    op;
  logic [FIELD_IDX_W-1:0]  unit_index;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [CAPS_W-1:0]       caps;
  logic                    visible;
  logic                    in_pool;
  logic signed [POS_W-1:0] target_x;
  logic signed [POS_W-1:0] target_y;
  logic [CAPS_W-1:0]       require_mask;
  logic                    holder_valid;
  logic [FIELD_IDX_W-1:0]  holder_index;

  assign op           = s_axis_tuser;
  assign unit_index   = s_axis_tdata[3:0];
  assign pos_x        = s_axis_tdata[19:4];
  assign pos_y        = s_axis_tdata[35:20];
  assign caps         = s_axis_tdata[39:36];
  assign visible      = s_axis_tdata[40];
  assign in_pool      = s_axis_tdata[41];
  assign target_x     = s_axis_tdata[57:42];
  assign target_y     = s_axis_tdata[73:58];
  assign require_mask = s_axis_tdata[77:74];
  assign holder_valid = s_axis_tdata[78];
  assign holder_index = s_axis_tdata[82:79];

  state_e state_q;

  // Request held for the length of an assign item
  logic signed [POS_W-1:0] tx_q;
  logic signed [POS_W-1:0] ty_q;
  logic [CAPS_W-1:0]       need_q;
  logic                    have_q;
  logic [FIELD_IDX_W-1:0]  hold_idx_q;
  logic                    hold_cap_q;
  logic                    keep_q;

  // Per-entry state kept in flip-flops
  logic [UNITS-1:0] valid_q;
  logic [UNITS-1:0] pool_q;

  // Scan pipeline: read stage, difference stage, square stage, compare
  logic [CNT_W-1:0]         scan_q;
  logic                     rd_vld_q;
  logic [UNIT_W-1:0]        rd_idx_q;
  logic                     rd_pool_q;
  logic                     rd_ent_vld_q;
  logic                     p1_vld_q;
  logic [UNIT_W-1:0]        p1_idx_q;
  logic                     p1_elig_q;
  logic signed [DIFF_W-1:0] p1_dx_q;
  logic signed [DIFF_W-1:0] p1_dy_q;
  logic                     p2_vld_q;
  logic [UNIT_W-1:0]        p2_idx_q;
  logic                     p2_elig_q;
  logic [DIST_W-1:0]        p2_dist_q;
  logic                     found_q;
  logic [UNIT_W-1:0]        best_idx_q;
  logic [DIST_W-1:0]        best_dist_q;

  // Output register
  logic                   out_vld_q;
  logic                   out_avalid_q;
  logic [FIELD_IDX_W-1:0] out_index_q;
  logic                   out_kept_q;
  logic                   out_success_q;

  // Table RAM
  logic              ram_we;
  logic [UNIT_W-1:0] ram_waddr;
  unit_entry_t       ram_wdata;
  logic [UNIT_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  unit_entry_t       rd_entry;

  logic in_fire;
  logic out_fire;
  logic fin_fire;
  logic scan_issue;
  logic scan_empty;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = out_vld_q && m_axis_tready;
  // The result may leave the sequencer once the output register is free or draining
  assign fin_fire      = (state_q == ST_FINISH) && (!out_vld_q || m_axis_tready);

  assign scan_issue = (state_q == ST_SCAN) && (scan_q < CNT_W'(UNITS));
  assign scan_empty = !scan_issue && !rd_vld_q && !p1_vld_q && !p2_vld_q;

  // Write the entry on a write item whose index falls within the table
  assign ram_we    = in_fire && (op == OP_WRITE) && in_range(unit_index);
  assign ram_waddr = to_unit(unit_index);
  assign ram_wdata = '{x: pos_x, y: pos_y, caps: caps, seen: visible};

  // Read port: the holder's entry first, then the scan walks every entry
  assign ram_raddr = (state_q == ST_SCAN) ? scan_q[UNIT_W-1:0] : to_unit(hold_idx_q);

  ncua_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(UNITS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // An entry never written reads as all zero
  assign rd_entry = rd_ent_vld_q ? unit_entry_t'(ram_rdata) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      pool_q       <= '0;
      rd_vld_q     <= 1'b0;
      p1_vld_q     <= 1'b0;
      p2_vld_q     <= 1'b0;
      found_q      <= 1'b0;
      out_vld_q    <= 1'b0;
      scan_q       <= '0;
      keep_q       <= 1'b0;
      have_q       <= 1'b0;
      rd_ent_vld_q <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one takes its place in the same cycle
      if (out_fire && !fin_fire) begin
        out_vld_q <= 1'b0;
      end

      // Valid bit of the entry that the read port is addressing
      rd_ent_vld_q <= valid_q[ram_raddr];

      // Advance the scan pipeline
      rd_vld_q  <= scan_issue;
      rd_idx_q  <= scan_q[UNIT_W-1:0];
      rd_pool_q <= pool_q[scan_q[UNIT_W-1:0]];

      p1_vld_q  <= rd_vld_q;
      p1_idx_q  <= rd_idx_q;
      p1_elig_q <= rd_pool_q && capable(need_q, rd_entry.caps);
      p1_dx_q   <= DIFF_W'(rd_entry.x) - DIFF_W'(tx_q);
      p1_dy_q   <= DIFF_W'(rd_entry.y) - DIFF_W'(ty_q);

      // Shared squared-distance unit; each square fits 32 bits unsigned
      p2_vld_q  <= p1_vld_q;
      p2_idx_q  <= p1_idx_q;
      p2_elig_q <= p1_elig_q;
      p2_dist_q <= DIST_W'($unsigned(SQ_W'(p1_dx_q) * SQ_W'(p1_dx_q)))
                 + DIST_W'($unsigned(SQ_W'(p1_dy_q) * SQ_W'(p1_dy_q)));

      // Keep the strictly nearer candidate, so ties stay with the lower index
      if (p2_vld_q && p2_elig_q && (!found_q || (p2_dist_q < best_dist_q))) begin
        found_q     <= 1'b1;
        best_idx_q  <= p2_idx_q;
        best_dist_q <= p2_dist_q;
      end

      if (scan_issue) begin
        scan_q <= scan_q + CNT_W'(1);
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire && (op == OP_WRITE)) begin
            if (in_range(unit_index)) begin
              valid_q[to_unit(unit_index)] <= 1'b1;
              pool_q[to_unit(unit_index)]  <= in_pool;
            end
          end else if (in_fire) begin
            tx_q       <= target_x;
            ty_q       <= target_y;
            need_q     <= require_mask;
            have_q     <= holder_valid && in_range(holder_index);
            hold_idx_q <= holder_index;
            state_q    <= ST_HREAD;
          end
        end
        ST_HREAD: begin
          // Holder entry is being read
          state_q <= ST_HEVAL;
        end
        ST_HEVAL: begin
          hold_cap_q <= capable(need_q, rd_entry.caps);
          if (have_q && rd_entry.seen && capable(need_q, rd_entry.caps)) begin
            keep_q  <= 1'b1;
            state_q <= ST_FINISH;
          end else begin
            keep_q  <= 1'b0;
            found_q <= 1'b0;
            scan_q  <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_empty) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (fin_fire) begin
            out_vld_q <= 1'b1;
            if (keep_q) begin
              out_avalid_q  <= 1'b1;
              out_index_q   <= hold_idx_q;
              out_kept_q    <= 1'b1;
              out_success_q <= 1'b1;
              pool_q[to_unit(hold_idx_q)] <= 1'b0;
            end else if (found_q) begin
              out_avalid_q  <= 1'b1;
              out_index_q   <= FIELD_IDX_W'(best_idx_q);
              out_kept_q    <= 1'b0;
              out_success_q <= 1'b1;
              pool_q[best_idx_q] <= 1'b0;
            end else if (have_q) begin
              // Nothing found: the old holder stays, judged on its own capabilities
              out_avalid_q  <= 1'b1;
              out_index_q   <= hold_idx_q;
              out_kept_q    <= 1'b0;
              out_success_q <= hold_cap_q;
            end else begin
              out_avalid_q  <= 1'b0;
              out_index_q   <= '0;
              out_kept_q    <= 1'b0;
              out_success_q <= 1'b0;
            end
            keep_q  <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_success_q, out_kept_q, out_index_q, out_avalid_q};

  // A kept holder leaves the free pool
  a_kept_leaves_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_fire && keep_q |=> !pool_q[to_unit($past(hold_idx_q))])
    else $error("kept holder still in the free pool");

  // A unit won by the search leaves the free pool
  a_found_leaves_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_fire && !keep_q && found_q |=> !pool_q[$past(best_idx_q)])
    else $error("searched unit still in the free pool");

  // Distance pipeline only carries entries while scanning
  a_pipe_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p1_vld_q || p2_vld_q) |-> (state_q == ST_SCAN))
    else $error("scan pipeline busy outside the scan");

  // Success is only reported with a valid assigned index
  a_success_has_holder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[0])
    else $error("success without a holder");

endmodule
